### design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers clocked on clk, disabled while rst_n is low
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// pre must always be followed in the same cycle by post
`define FBTP_ASSERT_IMPLY(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// cond must never hold
`define FBTP_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

### design/fbtp_pkg.sv
// ----------------------------------------------------------------------------
// fbtp_pkg
// shared types, constants and the character code map of the text packer
// ----------------------------------------------------------------------------
`default_nettype none

package fbtp_pkg;

    localparam int MAX_CHARS   = 4096;
    localparam int QUEUE_DEPTH = 4;
    localparam int BIT_COUNT_W = 15;
    localparam int CODE_W      = 5;
    localparam int BUF_W       = 12;

    localparam logic [7:0] CHAR_SPACE     = 8'd32;
    localparam logic [7:0] CHAR_COMMA     = 8'd44;
    localparam logic [7:0] CHAR_SEMICOLON = 8'd59;
    localparam logic [7:0] CHAR_PERIOD    = 8'd46;
    localparam logic [7:0] CHAR_COLON     = 8'd58;
    localparam logic [7:0] CHAR_BASE      = 8'd65;

    localparam logic [CODE_W-1:0] CODE_SPACE     = 5'd26;
    localparam logic [CODE_W-1:0] CODE_COMMA     = 5'd27;
    localparam logic [CODE_W-1:0] CODE_SEMICOLON = 5'd28;
    localparam logic [CODE_W-1:0] CODE_PERIOD    = 5'd29;
    localparam logic [CODE_W-1:0] CODE_COLON     = 5'd30;

    typedef struct packed {
        logic                   two;
        logic                   last;
        logic [7:0]             b0;
        logic [7:0]             b1;
        logic [BIT_COUNT_W-1:0] bit_count;
    } job_t;

    typedef struct packed {
        logic push;
        job_t job;
    } q_wr_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    function automatic logic [CODE_W-1:0] code_of(input logic [7:0] c);
        logic [7:0] diff;
        diff = c - CHAR_BASE;
        unique case (c)
            CHAR_SPACE:     code_of = CODE_SPACE;
            CHAR_COMMA:     code_of = CODE_COMMA;
            CHAR_SEMICOLON: code_of = CODE_SEMICOLON;
            CHAR_PERIOD:    code_of = CODE_PERIOD;
            CHAR_COLON:     code_of = CODE_COLON;
            default:        code_of = diff[CODE_W-1:0];
        endcase
    endfunction

endpackage

`default_nettype wire

### design/fbtp_if.sv
// ----------------------------------------------------------------------------
// fbtp_if
// valid/ready channels for text characters in and packed bytes out
// ----------------------------------------------------------------------------
`default_nettype none

interface fbtp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink   (input valid, input char_code, input is_last, output ready);
endinterface

interface fbtp_out_if;
    logic                             valid;
    logic                             ready;
    logic [7:0]                       packed_byte;
    logic                             last_byte;
    logic [fbtp_pkg::BIT_COUNT_W-1:0] bit_count;

    modport source (output valid, output packed_byte, output last_byte, output bit_count,
                    input ready);
    modport sink   (input valid, input packed_byte, input last_byte, input bit_count,
                    output ready);
endinterface

`default_nettype wire

### design/five_bit_text_packer_core.sv
// ----------------------------------------------------------------------------
// five_bit_text_packer_core
// packs text characters into bytes at five code bits per character
// ----------------------------------------------------------------------------
// One character item is accepted per clock cycle whenever the four-entry job
// queue between the packing front end and the byte output stage has room.
// Each item yields zero, one or two bytes; the output stage sends one byte
// per cycle while output ready is high, so an item whose leftover bits close
// a message yields two bytes. Since bytes average five eighths per character,
// a steady stream runs at one item per cycle with output ready held high. A
// completed byte goes through the job queue and then the output register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module five_bit_text_packer_core #(
    parameter int MAX_CHARS = fbtp_pkg::MAX_CHARS
) (
    input  logic       clk,
    input  logic       rst_n,
    fbtp_in_if.sink    text,
    fbtp_out_if.source pack
);

    fbtp_pkg::q_wr_t   q_wr;
    fbtp_pkg::q_stat_t q_stat;
    fbtp_pkg::job_t    head;
    logic              pop;
    logic              two_job_push;
    logic              inner_byte;

    fbtp_front #(
        .MAX_CHARS (MAX_CHARS)
    ) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text),
        .q_stat (q_stat),
        .q_wr   (q_wr)
    );

    fbtp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .pop    (pop),
        .q_stat (q_stat),
        .head   (head)
    );

    fbtp_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (head),
        .pop    (pop),
        .pack   (pack)
    );

    assign two_job_push = q_wr.push && q_wr.job.two;
    assign inner_byte   = pack.valid && !pack.last_byte;

    `FBTP_ASSERT_NEVER(a_queue_overflow, q_wr.push && q_stat.full && !pop, "job queue overflow")
    `FBTP_ASSERT_NEVER(a_queue_underflow, pop && q_stat.empty, "pop from empty job queue")
    `FBTP_ASSERT_IMPLY(a_last_job_nonempty, two_job_push, q_wr.job.last, "two-byte job not last")
    `FBTP_ASSERT_IMPLY(a_mid_byte_count, inner_byte, pack.bit_count == '0, "count on inner byte")

endmodule

`default_nettype wire

### design/fbtp_front.sv
// ----------------------------------------------------------------------------
// fbtp_front
// maps each character to its code, packs it into the bit buffer and queues
// the bytes that the item completes
// ----------------------------------------------------------------------------
`default_nettype none

module fbtp_front #(
    parameter int MAX_CHARS = fbtp_pkg::MAX_CHARS
) (
    input  logic              clk,
    input  logic              rst_n,
    fbtp_in_if.sink           text,
    input  fbtp_pkg::q_stat_t q_stat,
    output fbtp_pkg::q_wr_t   q_wr
);

    localparam int CountWidth = $clog2(MAX_CHARS + 1);
    localparam int ProdWidth  = (CountWidth + 3 > fbtp_pkg::BIT_COUNT_W) ?
                                CountWidth + 3 : fbtp_pkg::BIT_COUNT_W;

    logic [fbtp_pkg::BUF_W-1:0] buf_reg, buf_next;
    logic [2:0]                 pend_reg, pend_next;
    logic [CountWidth-1:0]      count_reg, count_next;

    logic                        accept;
    logic [fbtp_pkg::CODE_W-1:0] code;
    logic [fbtp_pkg::BUF_W-1:0]  merged;
    logic [fbtp_pkg::BUF_W-1:0]  rest_buf;
    logic [3:0]                  total;
    logic                        emit;
    logic [2:0]                  rest_pend;
    logic [CountWidth-1:0]       count_inc;
    logic [ProdWidth-1:0]        times5;

    assign text.ready = !q_stat.full;
    assign accept     = text.valid && text.ready;

    always_comb
    begin
        code      = fbtp_pkg::code_of(text.char_code);
        merged    = buf_reg | (fbtp_pkg::BUF_W'(code) << pend_reg);
        total     = {1'b0, pend_reg} + 4'd5;
        emit      = total[3];
        rest_pend = total[2:0];
        rest_buf  = emit ? {8'b0, merged[fbtp_pkg::BUF_W-1:8]} : merged;
        count_inc = (count_reg < CountWidth'(MAX_CHARS)) ? count_reg + 1'b1 : count_reg;
        times5    = (ProdWidth'(count_inc) << 2) + ProdWidth'(count_inc);

        q_wr.push          = accept && (emit || text.is_last);
        q_wr.job.two       = emit && text.is_last && (rest_pend != 3'd0);
        q_wr.job.last      = text.is_last;
        q_wr.job.b0        = merged[7:0];
        q_wr.job.b1        = rest_buf[7:0];
        q_wr.job.bit_count = text.is_last ? times5[fbtp_pkg::BIT_COUNT_W-1:0] : '0;

        buf_next   = buf_reg;
        pend_next  = pend_reg;
        count_next = count_reg;
        if (accept)
        begin
            if (text.is_last)
            begin
                buf_next   = '0;
                pend_next  = '0;
                count_next = '0;
            end
            else
            begin
                buf_next   = rest_buf;
                pend_next  = rest_pend;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_reg   <= '0;
            pend_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            buf_reg   <= buf_next;
            pend_reg  <= pend_next;
            count_reg <= count_next;
        end
    end

endmodule

`default_nettype wire

### design/fbtp_queue.sv
// ----------------------------------------------------------------------------
// fbtp_queue
// short first-in first-out queue of byte jobs between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module fbtp_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  fbtp_pkg::q_wr_t   q_wr,
    input  logic              pop,
    output fbtp_pkg::q_stat_t q_stat,
    output fbtp_pkg::job_t    head
);

    localparam int Depth     = fbtp_pkg::QUEUE_DEPTH;
    localparam int PtrWidth  = $clog2(Depth);
    localparam int FillWidth = $clog2(Depth + 1);

    fbtp_pkg::job_t        slots [Depth];
    logic [PtrWidth-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PtrWidth-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FillWidth-1:0]  fill_reg, fill_next;

    always_comb
    begin
        q_stat.full  = (fill_reg == FillWidth'(Depth));
        q_stat.empty = (fill_reg == '0);
        head         = slots[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (q_wr.push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (q_wr.push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !q_wr.push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr.push)
        begin
            slots[wr_ptr_reg] <= q_wr.job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

### design/fbtp_back.sv
// ----------------------------------------------------------------------------
// fbtp_back
// takes jobs from the queue and sends their bytes out one per cycle, unless
// the output stalls, through an output register
// ----------------------------------------------------------------------------
`default_nettype none

module fbtp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  fbtp_pkg::q_stat_t q_stat,
    input  fbtp_pkg::job_t    head,
    output logic              pop,
    fbtp_out_if.source        pack
);

    logic                             sel_reg, sel_next;
    logic                             valid_reg, valid_next;
    logic [7:0]                       byte_reg, byte_next;
    logic                             last_reg, last_next;
    logic [fbtp_pkg::BIT_COUNT_W-1:0] count_reg, count_next;

    logic load;
    logic first_half;

    assign pack.valid       = valid_reg;
    assign pack.packed_byte = byte_reg;
    assign pack.last_byte   = last_reg;
    assign pack.bit_count   = count_reg;

    always_comb
    begin
        load       = !q_stat.empty && (!valid_reg || pack.ready);
        first_half = head.two && !sel_reg;
        pop        = load && !first_half;

        sel_next   = sel_reg;
        valid_next = valid_reg;
        byte_next  = byte_reg;
        last_next  = last_reg;
        count_next = count_reg;
        if (load)
        begin
            valid_next = 1'b1;
            if (first_half)
            begin
                sel_next   = 1'b1;
                byte_next  = head.b0;
                last_next  = 1'b0;
                count_next = '0;
            end
            else
            begin
                sel_next   = 1'b0;
                byte_next  = sel_reg ? head.b1 : head.b0;
                last_next  = head.last;
                count_next = head.bit_count;
            end
        end
        else if (pack.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sel_reg   <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            sel_reg   <= sel_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg  <= byte_next;
        last_reg  <= last_next;
        count_reg <= count_next;
    end

endmodule

`default_nettype wire

### sim/fbtp_pack_checker.sv
// ----------------------------------------------------------------------------
// fbtp_pack_checker
// watches the character and byte channels, predicts the packed bytes of every
// accepted character item and compares each accepted byte with the oldest one
// still expected
// ----------------------------------------------------------------------------
module fbtp_pack_checker #(
    parameter int MAX_CHARS = fbtp_pkg::MAX_CHARS
) (
    input  logic clk,
    input  logic rst_n,
    fbtp_in_if   text,
    fbtp_out_if  pack,
    output int   errors,
    output int   outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0]                       data;
        logic                             last;
        logic [fbtp_pkg::BIT_COUNT_W-1:0] bits;
    } packed_byte_t;

    logic [fbtp_pkg::BUF_W-1:0] acc;
    logic [3:0]                 fill;
    logic [12:0]                chars;
    packed_byte_t               expected_bytes[$];

    function automatic logic [fbtp_pkg::CODE_W-1:0] char_to_code(input logic [7:0] c);
        logic [7:0] offset;
        offset = c - fbtp_pkg::CHAR_BASE;
        case (c)
            fbtp_pkg::CHAR_SPACE:     return fbtp_pkg::CODE_SPACE;
            fbtp_pkg::CHAR_COMMA:     return fbtp_pkg::CODE_COMMA;
            fbtp_pkg::CHAR_SEMICOLON: return fbtp_pkg::CODE_SEMICOLON;
            fbtp_pkg::CHAR_PERIOD:    return fbtp_pkg::CODE_PERIOD;
            fbtp_pkg::CHAR_COLON:     return fbtp_pkg::CODE_COLON;
            default:                  return offset[fbtp_pkg::CODE_W-1:0];
        endcase
    endfunction

    task automatic pack_char(input logic [7:0] c, input logic last);
        logic [fbtp_pkg::BUF_W-1:0] merged;
        logic [31:0]                total;
        packed_byte_t               rec;
        logic                       have;
        merged = acc | (fbtp_pkg::BUF_W'(char_to_code(c)) << fill);
        fill   = fill + 4'd5;
        if (chars < MAX_CHARS)
            chars = chars + 13'd1;
        have = 1'b0;
        rec  = '0;
        if (fill >= 4'd8)
        begin
            rec    = '{data: merged[7:0], last: 1'b0, bits: '0};
            have   = 1'b1;
            merged = merged >> 8;
            fill   = fill - 4'd8;
        end
        if (last)
        begin
            total = chars * 32'd5;
            if (fill != 4'd0)
            begin
                if (have)
                    expected_bytes.push_back(rec);
                rec  = '{data: merged[7:0], last: 1'b1,
                         bits: total[fbtp_pkg::BIT_COUNT_W-1:0]};
                have = 1'b1;
            end
            else
            begin
                // the byte just completed closes the message
                rec.last = 1'b1;
                rec.bits = total[fbtp_pkg::BIT_COUNT_W-1:0];
            end
            acc   = '0;
            fill  = '0;
            chars = '0;
        end
        else
        begin
            acc = merged;
        end
        if (have)
            expected_bytes.push_back(rec);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        packed_byte_t want;
        if (!rst_n)
        begin
            acc         = '0;
            fill        = '0;
            chars       = '0;
            errors      = 0;
            outstanding = 0;
            expected_bytes.delete();
        end
        else
        begin
            if (text.valid && text.ready)
                pack_char(text.char_code, text.is_last);
            if (pack.valid && pack.ready)
            begin
                if (expected_bytes.size() == 0)
                begin
                    errors = errors + 1;
                    $display("%0t: unexpected byte, expected none, ", $time,
                             "actual data %h last %b bits %0d",
                             pack.packed_byte, pack.last_byte, pack.bit_count);
                end
                else
                begin
                    want = expected_bytes.pop_front();
                    if (pack.packed_byte !== want.data || pack.last_byte !== want.last ||
                        pack.bit_count !== want.bits)
                    begin
                        errors = errors + 1;
                        $display("%0t: byte mismatch, expected data %h last %b bits %0d, ",
                                 $time, want.data, want.last, want.bits,
                                 "actual data %h last %b bits %0d",
                                 pack.packed_byte, pack.last_byte, pack.bit_count);
                    end
                end
            end
            outstanding = expected_bytes.size();
        end
    end

endmodule

### sim/tb_five_bit_text_packer_core.sv
// ----------------------------------------------------------------------------
// tb_five_bit_text_packer_core
// drives character messages into the packer with random gaps and output
// stalls: a few directed messages, then random messages; the checker
// predicts every byte
// ----------------------------------------------------------------------------
module tb_five_bit_text_packer_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT        = 200000;
    localparam int RANDOM_ITEMS = 1150;

    logic clk;
    logic rst_n;
    logic idle_on;
    int   errors;
    int   outstanding;
    int   cycles;
    int   sent;

    fbtp_in_if  text_ch();
    fbtp_out_if pack_ch();

    five_bit_text_packer_core u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .text  (text_ch),
        .pack  (pack_ch)
    );

    fbtp_pack_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .text        (text_ch),
        .pack        (pack_ch),
        .errors      (errors),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
        pack_ch.ready <= !idle_on || ($urandom_range(0, 99) >= 24);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return 8'($urandom_range(0, 255));
        if (r < 35)
        begin
            case ($urandom_range(0, 4))
                0:       return fbtp_pkg::CHAR_SPACE;
                1:       return fbtp_pkg::CHAR_COMMA;
                2:       return fbtp_pkg::CHAR_SEMICOLON;
                3:       return fbtp_pkg::CHAR_PERIOD;
                default: return fbtp_pkg::CHAR_COLON;
            endcase
        end
        return fbtp_pkg::CHAR_BASE + 8'($urandom_range(0, 25));
    endfunction

    task automatic push_char(input logic [7:0] c, input logic last);
        while (idle_on && $urandom_range(0, 99) < 24)
        begin
            text_ch.valid <= 1'b0;
            @(posedge clk);
        end
        text_ch.valid     <= 1'b1;
        text_ch.char_code <= c;
        text_ch.is_last   <= last;
        do
            @(posedge clk);
        while (!text_ch.ready);
        sent = sent + 1;
    endtask

    initial
    begin
        int len;
        rst_n             = 1'b0;
        idle_on           = 1'b1;
        cycles            = 0;
        sent              = 0;
        text_ch.valid     = 1'b0;
        text_ch.char_code = '0;
        text_ch.is_last   = 1'b0;
        pack_ch.ready     = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // single character, padding byte only
        push_char(fbtp_pkg::CHAR_BASE, 1'b1);
        // eight characters fill exactly five bytes, no padding byte
        push_char(8'h00, 1'b0);
        push_char(8'hFF, 1'b0);
        push_char(8'd64, 1'b0);
        push_char(8'd90, 1'b0);
        push_char(fbtp_pkg::CHAR_SPACE, 1'b0);
        push_char(fbtp_pkg::CHAR_COMMA, 1'b0);
        push_char(fbtp_pkg::CHAR_SEMICOLON, 1'b0);
        push_char(fbtp_pkg::CHAR_PERIOD, 1'b1);
        // last item completes a byte and leaves bits over
        push_char(fbtp_pkg::CHAR_COLON, 1'b0);
        push_char(8'd90, 1'b1);
        push_char(8'h55, 1'b0);
        push_char(8'hAA, 1'b0);
        push_char(8'h7F, 1'b1);

        while (sent < RANDOM_ITEMS)
        begin
            if (sent >= 350 && sent < 700)
                idle_on <= 1'b0;
            else
                idle_on <= 1'b1;
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 40);
            for (int i = 0; i < len; i++)
                push_char(pick_char(), i == len - 1);
        end
        text_ch.valid <= 1'b0;

        while (outstanding != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### five_bit_text_packer_core.f
+incdir+design
design/fbtp_pkg.sv
design/fbtp_if.sv
design/fbtp_front.sv
design/fbtp_queue.sv
design/fbtp_back.sv
design/five_bit_text_packer_core.sv
sim/fbtp_pack_checker.sv
sim/tb_five_bit_text_packer_core.sv
